// ===== hw/rtl/gbe_pkg.sv =====
// Shared types, constants and the 2^-f table for the gaussian basis evaluator.
// No dependencies; used by gbe_core and the top level of the block.
`default_nettype none

package gbe_pkg;

	localparam int NUM_BASIS = 16;
	localparam int IDX_W = $clog2(NUM_BASIS);
	localparam logic [6:0] NUM_BASIS_W = 7'(NUM_BASIS);

	typedef logic [1:0] op_t;
	localparam op_t OP_LOAD_C = 2'd0;
	localparam op_t OP_LOAD_W = 2'd1;
	localparam op_t OP_EVAL = 2'd2;

	localparam logic [16:0] LOG2E_Q16 = 17'd94548;
	localparam logic [23:0] T_MAX = 24'hFF_FFFF;
	localparam logic [16:0] HALF_Q16 = 17'd32768;
	localparam logic [16:0] ONE_Q16 = 17'd65536;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [16:0] act_t;
	typedef act_t [255:0] rom_t;

	typedef struct packed {
		logic [5:0] basis_index;
		act_t activation;
		logic last;
	} res_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] bt;
		v = v_in;
		res = '0;
		bt = 64'h4000_0000_0000_0000;
		for (int s = 0; s < 32; s++) begin
			if (bt > v) bt = bt >> 2;
		end
		for (int s = 0; s < 32; s++) begin
			if (bt != 0) begin
				if (v >= res + bt) begin
					v = v - (res + bt);
					res = (res >> 1) + bt;
				end else begin
					res = res >> 1;
				end
				bt = bt >> 2;
			end
		end
		return res;
	endfunction

	// tab[k] = 2^(-k/256) in Q1.16, built from chained square roots of 0.5 (Q1.31)
	function automatic rom_t build_rom();
		logic [7:0][63:0] roots;
		logic [63:0] r;
		logic [63:0] p;
		rom_t rom;
		r = 64'd1 << 30;
		for (int j = 0; j < 8; j++) begin
			r = isqrt64(r << 31);
			roots[j] = r;
		end
		for (int k = 0; k < 256; k++) begin
			p = 64'd1 << 31;
			for (int m = 0; m < 8; m++) begin
				if (((k >> m) & 1) != 0) p = (p * roots[7 - m] + (64'd1 << 30)) >> 31;
			end
			rom[k] = 17'((p + (64'd1 << 14)) >> 15);
		end
		return rom;
	endfunction

	localparam rom_t EXP_ROM = build_rom();

endpackage

`default_nettype wire

// ===== hw/rtl/gbe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gbe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/gbe_mul.sv =====
// Shared 32x32 unsigned multiplier with a registered product.
// No dependencies.
`default_nettype none

module gbe_mul (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] op_a,
	input  wire logic [31:0] op_b,
	output logic      [63:0] prod
);

	logic [63:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) prod_q <= 64'(op_a) * 64'(op_b);
	end

	assign prod = prod_q;

endmodule

`default_nettype wire

// ===== hw/rtl/gbe_core.sv =====
// Per-basis sequencer: walks all bases, drives the shared multiplier through
// five products per basis and holds the result register. Uses gbe_pkg, gbe_mul.
`default_nettype none

module gbe_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [31:0]         phase,
	output logic                     busy,
	output gbe_pkg::idx_t            rd_addr,
	input  wire logic [31:0]         center,
	input  wire logic [31:0]         width,
	output logic                     res_valid,
	input  wire logic                res_ready,
	output gbe_pkg::res_t            res
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_DIF,
		ST_SQR,
		ST_HHI,
		ST_HLO,
		ST_TSAT,
		ST_TMUL,
		ST_FRAC,
		ST_INTP,
		ST_OUT
	} state_t;

	state_t state_q;
	gbe_pkg::idx_t idx_q;
	logic res_valid_q;
	gbe_pkg::res_t res_q;

	// datapath
	logic [31:0] x_q;
	logic [31:0] ad_q;
	logic [31:0] d2lo_q;
	logic [39:0] alo_q;
	logic asat_q;
	logic [23:0] t_q;
	logic [4:0] n_q;
	logic zero_q;
	gbe_pkg::act_t ta_q;
	gbe_pkg::act_t tb_q;
	logic [7:0] w_q;

	logic mul_en;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;

	logic [32:0] diff;
	logic [56:0] tsum;
	logic [8:0] n_full;
	logic [7:0] k;
	gbe_pkg::act_t m_val;
	gbe_pkg::act_t act;
	logic out_free;
	logic last_basis;

	gbe_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (prod)
	);

	always_comb begin
		mul_en = 1'b1;
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SQR: begin
				mul_a = ad_q;
				mul_b = ad_q;
			end
			ST_HHI: begin
				mul_a = width;
				mul_b = prod[63:32];
			end
			ST_HLO: begin
				mul_a = width;
				mul_b = d2lo_q;
			end
			ST_TMUL: begin
				mul_a = 32'(t_q);
				mul_b = 32'(gbe_pkg::LOG2E_Q16);
			end
			ST_INTP: begin
				mul_a = 32'(ta_q - tb_q);
				mul_b = 32'(w_q);
			end
			default: mul_en = 1'b0;
		endcase
	end

	assign diff = {x_q[31], x_q} - {center[31], center};
	// h*d2 in Q.64 scaled down to Q8.16: (a<<16 + b>>16) >> 32
	assign tsum = {1'b0, alo_q, 16'b0} + 57'(prod[63:16]);
	assign n_full = prod[40:32];
	assign k = prod[31:24];
	assign m_val = ta_q - prod[24:8];
	assign act = zero_q ? '0 : (m_val >> n_q);
	assign out_free = !res_valid_q || res_ready;
	assign last_basis = idx_q == gbe_pkg::idx_t'(gbe_pkg::NUM_BASIS - 1);

	always_ff @(posedge clk) begin
		if (start) x_q <= phase;
		case (state_q)
			ST_DIF: ad_q <= diff[32] ? 32'(-diff) : diff[31:0];
			ST_HHI: d2lo_q <= prod[31:0];
			ST_HLO: begin
				alo_q <= prod[39:0];
				asat_q <= |prod[63:40];
			end
			ST_TSAT: t_q <= (asat_q || tsum[56]) ? gbe_pkg::T_MAX : tsum[55:32];
			ST_FRAC: begin
				zero_q <= n_full >= 9'd17;
				n_q <= n_full[4:0];
				w_q <= prod[23:16];
				ta_q <= gbe_pkg::EXP_ROM[k];
				tb_q <= (k == 8'hFF) ? gbe_pkg::HALF_Q16 : gbe_pkg::EXP_ROM[k + 8'd1];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			res_valid_q <= 1'b0;
			res_q <= '0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						idx_q <= '0;
						state_q <= ST_RD;
					end
				end
				ST_RD: state_q <= ST_DIF;
				ST_DIF: state_q <= ST_SQR;
				ST_SQR: state_q <= ST_HHI;
				ST_HHI: state_q <= ST_HLO;
				ST_HLO: state_q <= ST_TSAT;
				ST_TSAT: state_q <= ST_TMUL;
				ST_TMUL: state_q <= ST_FRAC;
				ST_FRAC: state_q <= ST_INTP;
				ST_INTP: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						res_q.basis_index <= 6'(idx_q);
						res_q.activation <= act;
						res_q.last <= last_basis;
						if (last_basis) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + gbe_pkg::idx_t'(1);
							state_q <= ST_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = state_q != ST_IDLE;
	assign rd_addr = idx_q;
	assign res_valid = res_valid_q;
	assign res = res_q;

endmodule

`default_nettype wire

// ===== hw/rtl/gaussian_basis_evaluator_unit.sv =====
// Top level of the gaussian basis evaluator: request decode, center and width
// storage, per-basis sequencer. Uses gbe_pkg, gbe_ram, gbe_core.
//
//  channel  dir  signals                      contents
//  s_*      in   tvalid tready tdata tuser    load center / load width / evaluate
//  m_*      out  tvalid tready tdata tlast    one activation per basis
//
// Loads write the center or width RAM directly. An evaluate steps each basis
// through its states, holding in ST_OUT while m_tready stalls the result
// register; its five products per basis go through the one shared 32x32
// multiplier. s_tready is low while an evaluate runs; a result can wait in
// the output register while the next request is taken. Reset clears control
// state only; centers and widths hold nothing defined until loaded.
`default_nettype none

module gaussian_basis_evaluator_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // [5:0] entry_index, [37:6] value, [39:38] zero
	input  wire logic [1:0]  s_tuser,  // [1:0] operation
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [23:0] m_tdata,  // [5:0] basis_index, [22:6] activation, [23] zero
	output logic             m_tlast
);

	logic req;
	logic idx_ok;
	logic [5:0] entry_index;
	logic [31:0] value;
	logic busy;
	gbe_pkg::idx_t rd_addr;
	logic [31:0] center;
	logic [31:0] width;
	gbe_pkg::res_t res;

	assign entry_index = s_tdata[5:0];
	assign value = s_tdata[37:6];
	assign req = s_tvalid && s_tready;
	assign idx_ok = {1'b0, entry_index} < gbe_pkg::NUM_BASIS_W;
	assign s_tready = !busy;

	gbe_ram #(
		.WIDTH (32),
		.DEPTH (gbe_pkg::NUM_BASIS)
	) u_centers (
		.clk   (clk),
		.we    (req && idx_ok && s_tuser == gbe_pkg::OP_LOAD_C),
		.waddr (gbe_pkg::idx_t'(entry_index)),
		.wdata (value),
		.raddr (rd_addr),
		.rdata (center)
	);

	gbe_ram #(
		.WIDTH (32),
		.DEPTH (gbe_pkg::NUM_BASIS)
	) u_widths (
		.clk   (clk),
		.we    (req && idx_ok && s_tuser == gbe_pkg::OP_LOAD_W),
		.waddr (gbe_pkg::idx_t'(entry_index)),
		.wdata (value),
		.raddr (rd_addr),
		.rdata (width)
	);

	gbe_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (req && s_tuser == gbe_pkg::OP_EVAL),
		.phase     (value),
		.busy      (busy),
		.rd_addr   (rd_addr),
		.center    (center),
		.width     (width),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tdata = {1'b0, res.activation, res.basis_index};
	assign m_tlast = res.last;

`ifndef SYNTHESIS
	a_eval_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == gbe_pkg::OP_EVAL) |=> !s_tready)
		else $error("evaluate request did not block the input");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> m_tdata[5:0] == 6'(gbe_pkg::NUM_BASIS - 1))
		else $error("tlast on a basis other than the final one");

	a_act_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[22:6] <= gbe_pkg::ONE_Q16)
		else $error("activation above 1.0");

	a_busy_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast && !s_tready) |-> !$past(m_tvalid && m_tlast && m_tready))
		else $error("evaluate still running after its final result was taken");
`endif

endmodule

`default_nettype wire
